>>> rtl/cos_pkg.sv
package cos_pkg;

    // Fixed arrow sprite geometry
    localparam int ARROW_WIDTH  = 12;
    localparam int ARROW_HEIGHT = 19;

    // Text cursor cell geometry, as shift amounts
    localparam int CELL_W_SHIFT = 3;
    localparam int CELL_H_SHIFT = 4;

    // Field widths
    localparam int DIM_CFG_W = 13;
    localparam int POS_W     = 16;
    localparam int CELL_IDX_W = 10;
    localparam int PIX_W     = 12;
    localparam int COLOR_W   = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // Overlay colors
    localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'h00FF_FFFF;
    localparam logic [COLOR_W-1:0] COLOR_BLACK = 32'h0000_0000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FB_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARROW_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARROW_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PACKED    = 3'd6;

    // Arrow sprite codes: transparent, black, white
    typedef enum logic [1:0] {
        AC_N = 2'd0,
        AC_K = 2'd1,
        AC_W = 2'd2
    } t_acode;

    // Arrow shape, row by row, column 0 first
    localparam t_acode ARROW_SHAPE [ARROW_HEIGHT][ARROW_WIDTH] = '{
        '{AC_K,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_W,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_W,AC_W,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_W,AC_W,AC_W,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_W,AC_W,AC_W,AC_W,AC_W,AC_K,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_W,AC_W,AC_W,AC_W,AC_W,AC_W,AC_K,AC_N,AC_N},
        '{AC_K,AC_W,AC_W,AC_W,AC_W,AC_K,AC_K,AC_K,AC_K,AC_K,AC_K,AC_N},
        '{AC_K,AC_W,AC_W,AC_K,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_W,AC_K,AC_N,AC_K,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_K,AC_K,AC_N,AC_N,AC_K,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_N,AC_N,AC_N,AC_N,AC_N,AC_K,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N},
        '{AC_N,AC_N,AC_N,AC_N,AC_N,AC_K,AC_W,AC_K,AC_N,AC_N,AC_N,AC_N},
        '{AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_K,AC_K,AC_N,AC_N,AC_N,AC_N},
        '{AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N},
        '{AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N,AC_N}
    };

    // Configuration register set
    typedef struct packed {
        logic [DIM_CFG_W-1:0]  fb_width;
        logic [DIM_CFG_W-1:0]  fb_height;
        logic [POS_W-1:0]      arrow_x;
        logic [POS_W-1:0]      arrow_y;
        logic [CELL_IDX_W-1:0] text_col;
        logic [CELL_IDX_W-1:0] text_row;
        logic                  packed_24bit;
    } t_cfg;

endpackage

>>> rtl/cos_overlay.sv
module cos_overlay #(
    parameter int MAX_DIM = 4096
) (
    input  cos_pkg::t_cfg                   i_cfg,
    input  logic [cos_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic [cos_pkg::PIX_W-1:0]       i_pixel_y,
    input  logic [cos_pkg::COLOR_W-1:0]     i_pixel_color,
    output logic [cos_pkg::COLOR_W-1:0]     o_color,
    output logic                            o_visible
);
    import cos_pkg::*;

    localparam int MAXD_W = $clog2(MAX_DIM + 1);
    localparam int CW     = (MAXD_W > DIM_CFG_W) ? MAXD_W : DIM_CFG_W;
    // Offset width: pixel minus a signed 16-bit position never overflows
    localparam int DW     = POS_W + 2;

    logic [CW-1:0] w_clamp;
    logic [CW-1:0] h_clamp;
    logic [DW-1:0] dx;
    logic [DW-1:0] dy;
    logic          in_arrow;
    t_acode        code;
    logic          text_ok;
    logic          in_text;

    // Geometry clamped to the largest supported frame
    always_comb begin
        w_clamp = (CW'(i_cfg.fb_width) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(i_cfg.fb_width);
        h_clamp = (CW'(i_cfg.fb_height) > CW'(MAX_DIM)) ? CW'(MAX_DIM) : CW'(i_cfg.fb_height);
    end

    assign o_visible = (CW'(i_pixel_x) < w_clamp) && (CW'(i_pixel_y) < h_clamp);

    // Offset into the arrow sprite
    assign dx = DW'(i_pixel_x) - {{(DW-POS_W){i_cfg.arrow_x[POS_W-1]}}, i_cfg.arrow_x};
    assign dy = DW'(i_pixel_y) - {{(DW-POS_W){i_cfg.arrow_y[POS_W-1]}}, i_cfg.arrow_y};

    assign in_arrow = !dx[DW-1] && (dx[DW-2:0] < (DW-1)'(ARROW_WIDTH)) &&
                      !dy[DW-1] && (dy[DW-2:0] < (DW-1)'(ARROW_HEIGHT));

    always_comb begin
        code = AC_N;
        if (in_arrow) begin
            code = ARROW_SHAPE[dy[4:0]][dx[3:0]];
        end
    end

    // Text cell only when the cursor lies inside the console grid
    assign text_ok = (CW'(i_cfg.text_col) < (w_clamp >> CELL_W_SHIFT)) &&
                     (CW'(i_cfg.text_row) < (h_clamp >> CELL_H_SHIFT));
    assign in_text = text_ok &&
        (CELL_IDX_W'(i_pixel_x[PIX_W-1:CELL_W_SHIFT]) == i_cfg.text_col) &&
        (CELL_IDX_W'(i_pixel_y[PIX_W-1:CELL_H_SHIFT]) == i_cfg.text_row);

    // Arrow first, text cell on top
    always_comb begin
        o_color = i_pixel_color;
        if (o_visible) begin
            unique case (code)
                AC_K:    o_color = COLOR_BLACK;
                AC_W:    o_color = COLOR_WHITE;
                default: o_color = i_pixel_color;
            endcase
            if (in_text) begin
                o_color = COLOR_WHITE;
            end
        end
    end

endmodule

>>> rtl/cursor_overlay_scanout_unit.sv
// The first result of an item passes through the input register and then the result register.
// Throughput: one item per cycle in 32-bit mode; in packed mode busy stays high
// after a visible pixel is taken, until the byte serializer that drives the
// result port can no longer collide with a new item.
// Padding pixels in packed mode give no result and do not raise busy.
// Reset (synchronous, active low) clears the valid flags, the byte count and
// all configuration registers to 0.
// Results cannot be stalled: each is shown for one cycle with o_valid.
module cursor_overlay_scanout_unit #(
    parameter int MAX_DIM = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cos_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cos_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              start,
    output logic                              busy,
    input  logic [cos_pkg::PIX_W-1:0]         i_pixel_x,
    input  logic [cos_pkg::PIX_W-1:0]         i_pixel_y,
    input  logic [cos_pkg::COLOR_W-1:0]       i_pixel_color,
    output logic                              o_valid,
    output logic [cos_pkg::COLOR_W-1:0]       o_out_data,
    output logic                              o_last_of_pixel
);
    import cos_pkg::*;

    t_cfg                r_cfg;
    logic                r_in_vld;
    logic [PIX_W-1:0]    r_px;
    logic [PIX_W-1:0]    r_py;
    logic [COLOR_W-1:0]  r_color;
    logic [1:0]          r_pend_cnt;
    logic [15:0]         r_pend_bytes;
    logic                r_out_vld;
    logic [COLOR_W-1:0]  r_out_data;
    logic                r_out_last;
    logic [COLOR_W-1:0]  ov_color;
    logic                ov_visible;
    logic                accept;

    // Hold off while the byte serializer would collide with a new item
    assign busy   = r_cfg.packed_24bit && ((r_in_vld && ov_visible) || (r_pend_cnt == 2'd2));
    assign accept = start && !busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FB_WIDTH:  r_cfg.fb_width     <= i_cfg_wdata[DIM_CFG_W-1:0];
                REG_FB_HEIGHT: r_cfg.fb_height    <= i_cfg_wdata[DIM_CFG_W-1:0];
                REG_ARROW_X:   r_cfg.arrow_x      <= i_cfg_wdata[POS_W-1:0];
                REG_ARROW_Y:   r_cfg.arrow_y      <= i_cfg_wdata[POS_W-1:0];
                REG_TEXT_COL:  r_cfg.text_col     <= i_cfg_wdata[CELL_IDX_W-1:0];
                REG_TEXT_ROW:  r_cfg.text_row     <= i_cfg_wdata[CELL_IDX_W-1:0];
                REG_PACKED:    r_cfg.packed_24bit <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px    <= i_pixel_x;
            r_py    <= i_pixel_y;
            r_color <= i_pixel_color;
        end
    end

    cos_overlay #(
        .MAX_DIM (MAX_DIM)
    ) u_overlay (
        .i_cfg         (r_cfg),
        .i_pixel_x     (r_px),
        .i_pixel_y     (r_py),
        .i_pixel_color (r_color),
        .o_color       (ov_color),
        .o_visible     (ov_visible)
    );

    // Result register and packed byte serializer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_cnt <= 2'd0;
        end else begin
            r_out_vld <= 1'b0;
            if (r_pend_cnt != 2'd0) begin
                r_out_vld  <= 1'b1;
                r_pend_cnt <= r_pend_cnt - 2'd1;
            end else if (r_in_vld) begin
                if (!r_cfg.packed_24bit) begin
                    r_out_vld <= 1'b1;
                end else if (ov_visible) begin
                    r_out_vld  <= 1'b1;
                    r_pend_cnt <= 2'd2;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pend_cnt != 2'd0) begin
            r_out_data   <= COLOR_W'(r_pend_bytes[7:0]);
            r_out_last   <= (r_pend_cnt == 2'd1);
            r_pend_bytes <= {8'h00, r_pend_bytes[15:8]};
        end else if (r_in_vld) begin
            if (r_cfg.packed_24bit) begin
                r_out_data   <= COLOR_W'(ov_color[7:0]);
                r_out_last   <= 1'b0;
                r_pend_bytes <= ov_color[23:8];
            end else begin
                r_out_data <= ov_color;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_out_data      = r_out_data;
    assign o_last_of_pixel = r_out_last;

endmodule
